/* rtl/avm_pkg.sv */
// Shared types, constants and tables of the seven-segment voltmeter display driver.
`default_nettype none

package avm_pkg;

  localparam int SampleBits        = 10;
  localparam int FullScaleW        = 14;
  localparam int PointW            = 2;
  localparam int SegW              = 8;
  localparam int EnableW           = 4;
  localparam int DigitCountDefault = 4;
  localparam int MaxDigits         = 8;
  localparam int QueueDepth        = 2;
  localparam int CfgIndexW         = 2;
  localparam int CfgDataW          = FullScaleW;

  localparam logic [CfgIndexW-1:0] CfgFullScale  = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgPointDigit = 2'd1;

  localparam logic OpTick = 1'b1;

  localparam logic [FullScaleW-1:0] FullScaleReset = 14'd500;
  localparam logic [PointW-1:0]     PointReset     = 2'd2;

  localparam int ValueW = FullScaleW;
  localparam int ProdW  = SampleBits + FullScaleW;
  localparam int FoldW  = ((FullScaleW > SampleBits) ? FullScaleW : SampleBits) + 1;
  localparam logic [SampleBits-1:0] SampleTop = '1;

  localparam int RecipShift = 2 * ValueW;
  localparam int RecipW     = RecipShift + 1;
  localparam longint unsigned RecipOne = 64'd1 << RecipShift;

  localparam logic [RecipW-1:0] RecipTen [MaxDigits] = '{
    RecipW'(RecipOne),
    RecipW'((RecipOne + 64'd9) / 64'd10),
    RecipW'((RecipOne + 64'd99) / 64'd100),
    RecipW'((RecipOne + 64'd999) / 64'd1000),
    RecipW'((RecipOne + 64'd9999) / 64'd10000),
    RecipW'(0),
    RecipW'(0),
    RecipW'(0)
  };

  localparam logic [SegW-1:0] SegFont [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [SegW-1:0] PointBit = 8'h80;

  typedef enum logic {
    KindSample,
    KindTick
  } kind_e;

  typedef struct packed {
    logic                  opcode;
    logic [SampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SegW-1:0]    segments;
    logic [EnableW-1:0] digit_enable;
  } out_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [SampleBits-1:0] sample;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic                 valid;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* rtl/adc_voltmeter_seven_seg_scan.sv */
// Top level of the four-digit seven-segment voltmeter display driver.
// The input channel takes items of two kinds. A sample item carries a converter
// reading, which is scaled by full_scale, split into decimal digits and stored as
// segment patterns; it produces no output item. A tick item produces one output
// item with the pattern and one-hot enable of the current digit, then the scan
// moves on to the next digit. Items flow through a two-entry queue and a three-stage
// pipeline (multiply, constant division, digit split), and a tick's output item is
// registered after the last stage. One item is taken per cycle while the input is not
// stalled; a tick always reflects every sample accepted before it.
// The configuration channel is always ready and should be written only while idle.
// Reset blanks all digits, points the scan at the units digit and loads a full
// scale of 500 with the point on digit 2. When the receiver stalls, the output
// item holds, the pipeline holds behind a waiting tick, and once the queue holds
// two items the input stall rises.
`default_nettype none

module adc_voltmeter_seven_seg_scan import avm_pkg::*; #(
  parameter int DIGIT_COUNT = DigitCountDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  q_head_t head;
  logic    pop;
  cfg_wr_t cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  avm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  avm_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_i       (cfg_wr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* rtl/avm_front.sv */
// Front end: accepts input items, classifies them and queues them for the back end.
`default_nettype none

module avm_front import avm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  input  wire logic     pop_i,
  output q_head_t       head_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  q_item_t         mem_q [QueueDepth];
  q_item_t         entry;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  assign in_stall_o = (count_q == CntW'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    entry.kind   = (in_item_i.opcode == OpTick) ? KindTick : KindSample;
    entry.sample = in_item_i.sample;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("Queue count exceeds its depth.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("Queue popped while empty.");
`endif

endmodule

`default_nettype wire

/* rtl/avm_back.sv */
// Back end: scales samples, splits them into digit patterns and scans the display.
`default_nettype none

module avm_back import avm_pkg::*; #(
  parameter int DIGIT_COUNT = DigitCountDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_head_t head_i,
  output logic         pop_o,
  input  wire cfg_wr_t cfg_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_item_o
);

  localparam int PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int QpW  = ValueW + RecipW;

  logic [FullScaleW-1:0] full_scale_q;
  logic [PointW-1:0]     point_q;

  logic                  advance;

  logic                  s1_valid_q;
  kind_e                 s1_kind_q;
  logic [ProdW-1:0]      s1_prod_q;

  logic                  s2_valid_q;
  kind_e                 s2_kind_q;
  logic [ValueW-1:0]     s2_value_q;

  logic                  s3_valid_q;
  kind_e                 s3_kind_q;
  logic [ValueW-1:0]     s3_quo_q [DIGIT_COUNT];

  logic [ValueW-1:0]     hi1;
  logic [SampleBits-1:0] lo1;
  logic [FoldW-1:0]      fold1;
  logic [FoldW-SampleBits-1:0] hi2;
  logic [SampleBits:0]   fold2;
  logic                  carry;
  logic [ValueW-1:0]     value;

  logic [QpW-1:0]        qprod [DIGIT_COUNT];
  logic [ValueW-1:0]     quo   [DIGIT_COUNT];
  logic [SegW-1:0]       new_pat [DIGIT_COUNT];

  logic [SegW-1:0]       pat_q [DIGIT_COUNT];
  logic [PosW-1:0]       scan_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;
  logic [EnableW-1:0]    enable;
  logic                  tick_fire;
  logic                  sample_fire;

  assign advance     = !(s3_valid_q && (s3_kind_q == KindTick) && out_valid_q && out_stall_i);
  assign pop_o       = head_i.valid && advance;
  assign tick_fire   = advance && s3_valid_q && (s3_kind_q == KindTick);
  assign sample_fire = advance && s3_valid_q && (s3_kind_q == KindSample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FullScaleReset;
      point_q      <= PointReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgFullScale:  full_scale_q <= cfg_i.data;
        CfgPointDigit: point_q      <= cfg_i.data[PointW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Division by 2^N-1 folds the high part back onto the low part twice.
  always_comb begin
    hi1   = s1_prod_q[ProdW-1:SampleBits];
    lo1   = s1_prod_q[SampleBits-1:0];
    fold1 = FoldW'(hi1) + FoldW'(lo1);
    hi2   = fold1[FoldW-1:SampleBits];
    fold2 = (SampleBits+1)'(hi2) + (SampleBits+1)'(fold1[SampleBits-1:0]);
    carry = (fold2 >= (SampleBits+1)'(SampleTop));
    value = hi1 + ValueW'(hi2) + ValueW'(carry);
  end

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_quo
    assign qprod[g] = QpW'(s2_value_q) * QpW'(RecipTen[g]);
    assign quo[g]   = qprod[g][RecipShift +: ValueW];
  end

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_pat
    logic [SegW-1:0] font;
    if (g < DIGIT_COUNT - 1) begin : g_low
      logic [ValueW-1:0] diff;
      assign diff = s3_quo_q[g] - (s3_quo_q[g+1] << 3) - (s3_quo_q[g+1] << 1);
      assign font = SegFont[diff[3:0]];
    end else begin : g_top
      assign font = (s3_quo_q[g] <= ValueW'(9)) ? SegFont[s3_quo_q[g][3:0]] : '0;
    end
    assign new_pat[g] = ((32'(point_q) == g) ? PointBit : '0) | font;
  end

  always_comb begin
    for (int b = 0; b < EnableW; b++) begin
      enable[b] = (32'(scan_q) == b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_kind_q  <= head_i.item.kind;
      s1_prod_q  <= ProdW'(head_i.item.sample) * ProdW'(full_scale_q);
      s2_kind_q  <= s1_kind_q;
      s2_value_q <= value;
      s3_kind_q  <= s2_kind_q;
      s3_quo_q   <= quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        pat_q[i] <= '0;
      end
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_fire) begin
        pat_q <= new_pat;
      end
      if (tick_fire) begin
        scan_q      <= (scan_q == PosW'(DIGIT_COUNT - 1)) ? '0 : scan_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      out_item_q.segments     <= pat_q[scan_q];
      out_item_q.digit_enable <= enable;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scan_q) < DIGIT_COUNT)
    else $error("Scan position beyond the last digit.");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && (s3_kind_q == KindTick) && out_valid_q && out_stall_i)
      |=> (s3_valid_q && (s3_kind_q == KindTick)))
    else $error("A waiting tick item left the last stage.");

  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(out_item_q.digit_enable))
    else $error("Digit enable has more than one bit set.");
`endif

endmodule

`default_nettype wire
